// File: hdl/trslm_pkg.sv
// ----------------------------------------------------------------------------
// trslm_pkg
// Shared widths, types and helpers for the local TRS matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package trslm_pkg;

   localparam int DataW    = 32;           // width of every field
   localparam int RotFrac  = 30;           // binary point of rotation entries
   localparam int PreTop   = RotFrac - 1;  // prescale puts the largest bit here
   localparam int NumIn    = 10;
   localparam int NumOut   = 12;
   localparam int NumRot   = 9;
   localparam int QuotW    = RotFrac + 2;  // raw quotient bits before rounding
   localparam int RemW     = 2 * RotFrac + 3;
   localparam int NormW    = 2 * RotFrac + 2;
   localparam int ProdW    = 2 * RotFrac + 2;
   localparam int CompW    = RotFrac + 1;
   localparam int TopW     = $clog2(DataW);

   typedef logic [DataW-1:0] word_type;

   // Fields that ride alongside the rotation math
   typedef struct packed {
      logic [2:0][DataW-1:0] pos;
      logic [2:0]            sneg;
      logic [2:0][DataW-1:0] smag;
   } side_type;

   // Magnitude of a two's complement word; the most negative value maps to 2^(W-1)
   function automatic word_type mag_of(input word_type raw);
      mag_of = raw[DataW-1] ? (~raw + word_type'(1)) : raw;
   endfunction

   // Position of the highest set bit
   function automatic logic [TopW-1:0] lead_one(input word_type val);
      lead_one = '0;
      for (int i = 0; i < DataW; i++) begin
         if (val[i]) begin
            lead_one = TopW'(i);
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: hdl/trs_local_matrix.sv
// ----------------------------------------------------------------------------
// trs_local_matrix
// Builds the local affine matrix T*R*S of one node from position, quaternion
// and scale, streaming one node per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one node per beat: position, quaternion (any length) and
//   per-axis scale, signed Q16.16. rsp_* returns one beat per node with the
//   twelve upper entries of the matrix, columns of the scaled rotation first,
//   then the translation column. Outputs saturate; a zero quaternion yields
//   the identity rotation.
//   When the output side does not stall, throughput is one node per cycle:
//   the work runs through 38 register stages (magnitude, prescale, products,
//   sums, 32 restoring divide steps, scale multiply, round and saturate).
//   Each stage has its own valid bit and advances when it is empty or its
//   successor advances, so bubbles close up and a stall on rsp_tready holds
//   every beat in place; req_tready drops only when all stages are full.
//   Reset clears all valid bits; no beat is output until one is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_local_matrix (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
   input  wire logic [trslm_pkg::NumIn*trslm_pkg::DataW-1:0]  req_tdata,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2,
   // m_r0c3, m_r1c3, m_r2c3
   output logic [trslm_pkg::NumOut*trslm_pkg::DataW-1:0] rsp_tdata
);
   import trslm_pkg::*;

   localparam int DivSteps = QuotW;
   localparam int StDiv    = 4;
   localparam int StMul    = StDiv + DivSteps;
   localparam int StOut    = StMul + 1;
   localparam int NumSt    = StOut + 1;

   // product slots
   localparam int PXX = 0, PYY = 1, PZZ = 2, PWW = 3, PXY = 4;
   localparam int PZW = 5, PXZ = 6, PYW = 7, PYZ = 8, PXW = 9;

   // ---------------------------------------------------------------- handshake
   logic [NumSt-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NumSt-1] = !v_ff[NumSt-1] || rsp_tready;
      for (int i = NumSt - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
      for (int i = 0; i < NumSt; i++) begin
         v_in[i] = adv[i] ? ((i == 0) ? req_tvalid : v_ff[(i == 0) ? 0 : i-1]) : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[NumSt-1];

   // ---------------------------------------------------------------- stage 0: magnitudes
   word_type   s0_qm_ff [4];
   logic [3:0] s0_qneg_ff;
   word_type   s0_max_ff;
   side_type   s0_side_ff;

   word_type   qm_in [4];
   word_type   max_a, max_b, max_in;
   side_type   side_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qm_in[i] = mag_of(req_tdata[(3+i)*DataW +: DataW]);
      end
      max_a  = (qm_in[0] > qm_in[1]) ? qm_in[0] : qm_in[1];
      max_b  = (qm_in[2] > qm_in[3]) ? qm_in[2] : qm_in[3];
      max_in = (max_a > max_b) ? max_a : max_b;
      for (int i = 0; i < 3; i++) begin
         side_in.pos[i]  = req_tdata[i*DataW +: DataW];
         side_in.sneg[i] = req_tdata[(7+i)*DataW + DataW - 1];
         side_in.smag[i] = mag_of(req_tdata[(7+i)*DataW +: DataW]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 4; i++) begin
            s0_qm_ff[i]   <= qm_in[i];
            s0_qneg_ff[i] <= req_tdata[(3+i)*DataW + DataW - 1];
         end
         s0_max_ff  <= max_in;
         s0_side_ff <= side_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: prescale
   logic signed [CompW-1:0] s1_c_ff [4];
   logic                    s1_zero_ff;
   side_type                s1_side_ff;

   logic signed [CompW-1:0] c_in [4];
   logic [TopW-1:0]         top;
   word_type                shifted;

   always_comb begin
      top = lead_one(s0_max_ff);
      for (int i = 0; i < 4; i++) begin
         if (top > TopW'(PreTop)) begin
            shifted = s0_qm_ff[i] >> (top - TopW'(PreTop));
         end else begin
            shifted = s0_qm_ff[i] << (TopW'(PreTop) - top);
         end
         c_in[i] = s0_qneg_ff[i] ? -$signed({1'b0, shifted[RotFrac-1:0]})
                                 :  $signed({1'b0, shifted[RotFrac-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_c_ff    <= c_in;
         s1_zero_ff <= (s0_max_ff == '0);
         s1_side_ff <= s0_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   logic signed [ProdW-1:0] s2_p_ff [NumIn];
   logic                    s2_zero_ff;
   side_type                s2_side_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         // x=c0 y=c1 z=c2 w=c3
         s2_p_ff[PXX] <= s1_c_ff[0] * s1_c_ff[0];
         s2_p_ff[PYY] <= s1_c_ff[1] * s1_c_ff[1];
         s2_p_ff[PZZ] <= s1_c_ff[2] * s1_c_ff[2];
         s2_p_ff[PWW] <= s1_c_ff[3] * s1_c_ff[3];
         s2_p_ff[PXY] <= s1_c_ff[0] * s1_c_ff[1];
         s2_p_ff[PZW] <= s1_c_ff[2] * s1_c_ff[3];
         s2_p_ff[PXZ] <= s1_c_ff[0] * s1_c_ff[2];
         s2_p_ff[PYW] <= s1_c_ff[1] * s1_c_ff[3];
         s2_p_ff[PYZ] <= s1_c_ff[1] * s1_c_ff[2];
         s2_p_ff[PXW] <= s1_c_ff[0] * s1_c_ff[3];
         s2_zero_ff   <= s1_zero_ff;
         s2_side_ff   <= s1_side_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: norm and numerators
   logic [NormW-1:0]  s3_n_ff;
   logic signed [63:0] s3_num_ff [NumRot];
   logic              s3_zero_ff;
   side_type          s3_side_ff;

   logic signed [63:0] px [NumIn];
   logic signed [63:0] num_in [NumRot];
   logic signed [63:0] n_in;

   always_comb begin
      for (int i = 0; i < NumIn; i++) begin
         px[i] = 64'(s2_p_ff[i]);
      end
      n_in      = px[PXX] + px[PYY] + px[PZZ] + px[PWW];
      num_in[0] = px[PWW] + px[PXX] - px[PYY] - px[PZZ];
      num_in[1] = (px[PXY] + px[PZW]) <<< 1;
      num_in[2] = (px[PXZ] - px[PYW]) <<< 1;
      num_in[3] = (px[PXY] - px[PZW]) <<< 1;
      num_in[4] = px[PWW] - px[PXX] + px[PYY] - px[PZZ];
      num_in[5] = (px[PYZ] + px[PXW]) <<< 1;
      num_in[6] = (px[PXZ] + px[PYW]) <<< 1;
      num_in[7] = (px[PYZ] - px[PXW]) <<< 1;
      num_in[8] = px[PWW] - px[PXX] - px[PYY] + px[PZZ];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_n_ff    <= n_in[NormW-1:0];
         s3_num_ff  <= num_in;
         s3_zero_ff <= s2_zero_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // ---------------------------------------------------------------- divide: one quotient bit per stage
   logic [RemW-1:0]  d_r_ff    [DivSteps][NumRot];
   logic [QuotW-1:0] d_q_ff    [DivSteps][NumRot];
   logic [NumRot-1:0] d_neg_ff [DivSteps];
   logic [NormW-1:0] d_n_ff    [DivSteps];
   logic             d_zero_ff [DivSteps];
   side_type         d_side_ff [DivSteps];

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      logic [RemW-1:0]   r_sh [NumRot];
      logic [QuotW-1:0]  q_pv [NumRot];
      logic [NormW-1:0]  n_pv;
      logic [NumRot-1:0] neg_pv;
      logic              zero_pv;
      side_type          side_pv;
      logic [63:0]       abs_num;

      always_comb begin
         abs_num = '0;
         for (int e = 0; e < NumRot; e++) begin
            if (k == 0) begin
               abs_num   = s3_num_ff[e][63] ? 64'(-s3_num_ff[e]) : 64'(s3_num_ff[e]);
               r_sh[e]   = abs_num[RemW-1:0];
               q_pv[e]   = '0;
               neg_pv[e] = s3_num_ff[e][63];
            end else begin
               r_sh[e]   = {d_r_ff[(k == 0) ? 0 : k-1][e][RemW-2:0], 1'b0};
               q_pv[e]   = d_q_ff[(k == 0) ? 0 : k-1][e];
               neg_pv[e] = d_neg_ff[(k == 0) ? 0 : k-1][e];
            end
         end
         n_pv    = (k == 0) ? s3_n_ff    : d_n_ff[(k == 0) ? 0 : k-1];
         zero_pv = (k == 0) ? s3_zero_ff : d_zero_ff[(k == 0) ? 0 : k-1];
         side_pv = (k == 0) ? s3_side_ff : d_side_ff[(k == 0) ? 0 : k-1];
      end

      // compare, subtract and shift in one quotient bit
      always_ff @(posedge clock) begin
         if (adv[StDiv+k]) begin
            for (int e = 0; e < NumRot; e++) begin
               if (r_sh[e] >= RemW'(n_pv)) begin
                  d_r_ff[k][e] <= r_sh[e] - RemW'(n_pv);
                  d_q_ff[k][e] <= {q_pv[e][QuotW-2:0], 1'b1};
               end else begin
                  d_r_ff[k][e] <= r_sh[e];
                  d_q_ff[k][e] <= {q_pv[e][QuotW-2:0], 1'b0};
               end
            end
            d_neg_ff[k]  <= neg_pv;
            d_n_ff[k]    <= n_pv;
            d_zero_ff[k] <= zero_pv;
            d_side_ff[k] <= side_pv;
         end
      end
   end

   // ---------------------------------------------------------------- scale multiply
   logic [DataW+RotFrac:0] m_prod_ff [NumRot];
   logic [NumRot-1:0]      m_neg_ff;
   side_type               m_side_ff;

   logic [QuotW:0]   q_rnd [NumRot];
   logic [RotFrac:0] rq    [NumRot];
   logic             rneg  [NumRot];

   always_comb begin
      for (int e = 0; e < NumRot; e++) begin
         q_rnd[e] = {1'b0, d_q_ff[DivSteps-1][e]} + (QuotW+1)'(1);
         if (d_zero_ff[DivSteps-1]) begin
            rq[e]   = (e == 0 || e == 4 || e == 8) ? (RotFrac+1)'(1) << RotFrac : '0;
            rneg[e] = 1'b0;
         end else begin
            rq[e]   = q_rnd[e][RotFrac+1:1];
            rneg[e] = d_neg_ff[DivSteps-1][e];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StMul]) begin
         for (int e = 0; e < NumRot; e++) begin
            m_prod_ff[e] <= (DataW+RotFrac+1)'(d_side_ff[DivSteps-1].smag[e/3])
                            * (DataW+RotFrac+1)'(rq[e]);
            m_neg_ff[e]  <= d_side_ff[DivSteps-1].sneg[e/3] ^ rneg[e];
         end
         m_side_ff <= d_side_ff[DivSteps-1];
      end
   end

   // ---------------------------------------------------------------- round, saturate, output register
   word_type out_ff [NumOut];
   word_type out_in [NumOut];
   logic [DataW+RotFrac+1:0] rnd_sum [NumRot];
   logic [DataW+1:0]         mag     [NumRot];
   localparam logic [DataW+1:0] Lim = (DataW+2)'(1) << (DataW - 1);

   always_comb begin
      for (int e = 0; e < NumRot; e++) begin
         rnd_sum[e] = {1'b0, m_prod_ff[e]} + ((DataW+RotFrac+2)'(1) << (RotFrac - 1));
         mag[e]     = rnd_sum[e][DataW+RotFrac+1:RotFrac];
         if (mag[e] == '0) begin
            out_in[e] = '0;
         end else if (m_neg_ff[e]) begin
            out_in[e] = (mag[e] > Lim) ? (~Lim[DataW-1:0] + word_type'(1))
                                       : (~mag[e][DataW-1:0] + word_type'(1));
         end else begin
            out_in[e] = (mag[e] > Lim - (DataW+2)'(1)) ? word_type'(Lim - (DataW+2)'(1))
                                                       : mag[e][DataW-1:0];
         end
      end
      for (int r = 0; r < 3; r++) begin
         out_in[NumRot+r] = m_side_ff.pos[r];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StOut]) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      for (int j = 0; j < NumOut; j++) begin
         rsp_tdata[j*DataW +: DataW] = out_ff[j];
      end
   end

endmodule

`default_nettype wire

// File: hdl/trslm_checker.sv
// ----------------------------------------------------------------------------
// trslm_checker
// Port-level checks for the local TRS matrix pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trslm_checker (
   input wire logic                                          clock,
   input wire logic                                          reset,
   input wire logic                                          req_tready,
   input wire logic                                          rsp_tvalid,
   input wire logic                                          rsp_tready,
   input wire logic [trslm_pkg::NumOut*trslm_pkg::DataW-1:0] rsp_tdata
);
   import trslm_pkg::*;

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed under stall");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // a free output drains the whole pipe, so the input is open
   a_ready_flow: assert property (@(posedge clock)
      rsp_tready |-> req_tready)
      else $error("input blocked while output is free");

   // the input closes only when a full pipe is stalled at the output
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input blocked without output stall");

endmodule

bind trs_local_matrix trslm_checker u_trslm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: test/trs_local_matrix_tb.sv
// ----------------------------------------------------------------------------
// trs_local_matrix_tb
// Self-checking bench for the local TRS matrix pipeline: directed and random
// nodes stream in under random idling and long output stalls; each response
// beat is compared entry by entry with a bit-exact matrix predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_local_matrix_tb;
   import trslm_pkg::*;

   localparam int ReqW = NumIn * DataW;
   localparam int RspW = NumOut * DataW;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
   logic [ReqW-1:0] req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   // m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2,
   // m_r0c3, m_r1c3, m_r2c3
   logic [RspW-1:0] rsp_tdata;

   logic [RspW-1:0] matrix_queue[$];
   int              error_count = 0;
   int              node_count = 0;
   int              matrix_count = 0;
   int              sat_count = 0;
   bit              no_idle = 1'b0;
   int              rsp_hold_cycles = 0;

   trs_local_matrix i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("trs_local_matrix verification failed");
      $finish;
   end

   // |num| * 2^30 / n, rounded half up, by restoring division
   function automatic longint unsigned rot_quotient(input longint num,
                                                    input longint unsigned n);
      longint unsigned r;
      longint unsigned q;
      r = (num < 0) ? longint'(0) - num : num;
      q = 0;
      if (r >= n) begin
         r = r - n;
         q = 1;
      end
      for (int i = 0; i < RotFrac + 1; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= n) begin
            r = r - n;
            q = q | 1;
         end
      end
      return (q + 1) >> 1;
   endfunction

   function automatic word_type magnitude(input word_type raw);
      return raw[DataW-1] ? (~raw + 1'b1) : raw;
   endfunction

   // Bit-exact T*R*S matrix of one node
   function automatic logic [RspW-1:0] predict_matrix(input logic [ReqW-1:0] node);
      longint unsigned qm[4];
      bit              qneg[4];
      longint          c[4];
      longint          num[9];
      longint unsigned rq[9];
      bit              rneg[9];
      longint unsigned maxm;
      longint unsigned n;
      longint unsigned m;
      longint unsigned smag;
      longint unsigned prod;
      longint          xx, yy, zz, ww, x, y, z, w;
      int              top;
      bit              sneg;
      bit              oneg;
      word_type        sraw;
      logic [RspW-1:0] res;
      maxm = 0;
      res = '0;
      for (int i = 0; i < 4; i++) begin
         qneg[i] = node[(3+i)*DataW+DataW-1];
         qm[i]   = magnitude(node[(3+i)*DataW +: DataW]);
         if (qm[i] > maxm) maxm = qm[i];
      end
      if (maxm == 0) begin
         // zero quaternion: identity rotation
         for (int i = 0; i < 9; i++) begin
            rneg[i] = 1'b0;
            rq[i]   = (i == 0 || i == 4 || i == 8) ? (64'd1 << RotFrac) : 0;
         end
      end else begin
         top = 0;
         while (top < 63 && (maxm >> (top + 1)) != 0) top++;
         for (int i = 0; i < 4; i++) begin
            m    = (top > PreTop) ? (qm[i] >> (top - PreTop)) : (qm[i] << (PreTop - top));
            c[i] = qneg[i] ? -longint'(m) : longint'(m);
         end
         x = c[0]; y = c[1]; z = c[2]; w = c[3];
         xx = x * x; yy = y * y; zz = z * z; ww = w * w;
         n = xx + yy + zz + ww;
         num[0] = ww + xx - yy - zz;
         num[1] = 2 * (x * y + z * w);
         num[2] = 2 * (x * z - y * w);
         num[3] = 2 * (x * y - z * w);
         num[4] = ww - xx + yy - zz;
         num[5] = 2 * (y * z + x * w);
         num[6] = 2 * (x * z + y * w);
         num[7] = 2 * (y * z - x * w);
         num[8] = ww - xx - yy + zz;
         for (int i = 0; i < 9; i++) begin
            rneg[i] = num[i] < 0;
            rq[i]   = rot_quotient(num[i], n);
         end
      end
      // scale columns, round and saturate
      for (int col = 0; col < 3; col++) begin
         sraw = node[(7+col)*DataW +: DataW];
         sneg = sraw[DataW-1];
         smag = magnitude(sraw);
         for (int row = 0; row < 3; row++) begin
            prod = (smag * rq[col*3+row] + (64'd1 << (RotFrac - 1))) >> RotFrac;
            oneg = sneg != rneg[col*3+row];
            if (prod == 0) begin
               res[(col*3+row)*DataW +: DataW] = '0;
            end else if (oneg) begin
               if (prod > (64'd1 << (DataW - 1))) prod = 64'd1 << (DataW - 1);
               res[(col*3+row)*DataW +: DataW] = word_type'(64'd0 - prod);
            end else begin
               if (prod > (64'd1 << (DataW - 1)) - 1) prod = (64'd1 << (DataW - 1)) - 1;
               res[(col*3+row)*DataW +: DataW] = word_type'(prod);
            end
         end
      end
      for (int row = 0; row < 3; row++) begin
         res[(9+row)*DataW +: DataW] = node[row*DataW +: DataW];
      end
      return res;
   endfunction

   function automatic logic [ReqW-1:0] pack_node(
      input word_type px, py, pz, qx, qy, qz, qw, sx, sy, sz);
      return {sz, sy, sx, qw, qz, qy, qx, pz, py, px};
   endfunction

   // Offer one node; hold valid until the beat is taken
   task automatic send_node(input logic [ReqW-1:0] node);
      int gap;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 99) < 17) begin
         gap = $urandom_range(1, 4);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = node;
      do @(posedge clock); while (!req_tready);
      matrix_queue.insert(matrix_queue.size(), predict_matrix(node));
      node_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (matrix_queue.size() != 0) @(negedge clock);
   endtask

   function automatic word_type rand_word();
      word_type v;
      case ($urandom_range(0, 6))
         0: v = '0;
         1: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         2: v = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         3: v = $urandom >> $urandom_range(0, 31);
         4: v = -($urandom >> $urandom_range(0, 31));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [ReqW-1:0] rand_node();
      return pack_node($urandom, $urandom, $urandom, rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
   endfunction

   // Edge cases: identity, saturation, prescale underflow, half turns
   task automatic test_directed();
      word_type one;
      word_type neg_max;
      word_type pos_max;
      one     = 32'h0001_0000;
      neg_max = 32'h8000_0000;
      pos_max = 32'h7fff_ffff;
      send_node(pack_node(0, 0, 0, 0, 0, 0, 0, one, one, one));
      send_node(pack_node(pos_max, neg_max, 1, 0, 0, 0, 0, neg_max, pos_max, neg_max));
      send_node(pack_node(neg_max, pos_max, -1, 0, 0, 0, one, neg_max, neg_max, neg_max));
      send_node(pack_node(1, 2, 3, 0, 0, 0, neg_max, pos_max, pos_max, pos_max));
      send_node(pack_node(0, 0, 0, neg_max, neg_max, neg_max, neg_max, one, one, one));
      send_node(pack_node(0, 0, 0, pos_max, pos_max, pos_max, pos_max, neg_max, one, -one));
      send_node(pack_node(0, 0, 0, one, 0, 0, 0, one, one, one));
      send_node(pack_node(0, 0, 0, 0, one, 0, 0, one, neg_max, one));
      send_node(pack_node(0, 0, 0, 0, 0, one, 0, one, one, neg_max));
      send_node(pack_node(0, 0, 0, pos_max, 1, -1, 1, one, one, one));
      send_node(pack_node(0, 0, 0, 1, 0, 0, 0, 3, 5, 7));
      send_node(pack_node(0, 0, 0, -1, 1, -1, 1, 1, -1, 1));
      send_node(pack_node(0, 0, 0, 3, 0, 0, 4, pos_max, neg_max, 32'h0000_8000));
      send_node(pack_node(5, 6, 7, one, one, 0, 0, -one, 32'h0001_8000, 2));
      send_node(pack_node(0, 0, 0, 1, 1, 1, 1, 1, 1, 1));
      send_node(pack_node(0, 0, 0, 32'h4000_0000, 0, 0, 32'h4000_0000, neg_max, neg_max, 1));
      wait_drained();
   endtask

   // Random nodes, with one long stretch where neither side idles
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         no_idle = (i >= count / 3) && (i < count / 2);
         send_node(rand_node());
      end
      no_idle = 1'b0;
   endtask

   // Stall the output long enough to fill every stage, then drain
   task automatic test_backpressure();
      rsp_hold_cycles = 150;
      for (int i = 0; i < 100; i++) begin
         send_node(rand_node());
      end
      wait_drained();
   endtask

   // Output ready, with random idling or a counted stall
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 17);
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin
      logic [RspW-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (matrix_queue.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = matrix_queue.pop_front();
            matrix_count++;
            for (int k = 0; k < NumOut; k++) begin
               if (rsp_tdata[k*DataW +: DataW] != want[k*DataW +: DataW]) begin
                  $display("%0t: entry %0d expected %h actual %h", $time, k,
                           want[k*DataW +: DataW], rsp_tdata[k*DataW +: DataW]);
                  error_count++;
               end
               if (k < 9 && (want[k*DataW +: DataW] == 32'h7fff_ffff ||
                             want[k*DataW +: DataW] == 32'h8000_0000)) begin
                  sat_count++;
               end
            end
         end
      end
   end

   initial begin
      int wait_cycles;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(800);
      test_backpressure();
      test_random(830);
      wait_drained();
      wait_cycles = 0;
      while (wait_cycles < 60) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (matrix_queue.size() != 0) error_count++;
      $display("Sent %0d nodes, checked %0d matrices (%0d entries at a rail),", node_count,
               matrix_count, sat_count);
      $display("including directed edge cases, full output stalls and idle-free bursts.");
      if (error_count == 0) begin
         $display("trs_local_matrix verification clean");
      end else begin
         $display("trs_local_matrix verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hdl/trslm_pkg.sv
hdl/trs_local_matrix.sv
hdl/trslm_checker.sv
test/trs_local_matrix_tb.sv
